// File: rtl/tonc_pkg.sv
package tonc_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_SEND = 8'd1;
  localparam logic [7:0] B_IS   = 8'd0;

  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_NAWS  = 8'd31;

  localparam int LEN_W = 4;
  localparam int SEQ_W = 4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [1:0] CFG_TT_CHARS = 2'd0;
  localparam logic [1:0] CFG_TT_LEN   = 2'd1;
  localparam logic [1:0] CFG_COLUMNS  = 2'd2;
  localparam logic [1:0] CFG_ROWS     = 2'd3;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_REPLY3,
    CMD_NAWS,
    CMD_TTIS
  } cmd_kind_t;

  // One classified command, expanded to beats by the back end.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       echo;
  } cmd_t;

endpackage

// File: rtl/tonc_front.sv
module tonc_front
  import tonc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       tt_present,
  output logic       q_push,
  output cmd_t       q_wdata
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_IAC,
    PH_OPT,
    PH_SUB
  } phase_t;

  typedef enum logic [2:0] {
    V_SB,
    V_DO,
    V_DONT,
    V_WILL,
    V_WONT
  } verb_t;

  phase_t     phase_r, phase_nxt;
  verb_t      verb_r, verb_nxt;
  logic [1:0] sub_cnt_r, sub_cnt_nxt;
  logic       sub_match_r, sub_match_nxt;
  logic       push_c;
  cmd_t       cmd_c;
  logic [7:0] want;
  logic       match_c;

  always_comb begin
    phase_nxt     = PH_IDLE;
    verb_nxt      = verb_r;
    sub_cnt_nxt   = sub_cnt_r;
    sub_match_nxt = sub_match_r;
    push_c        = 1'b0;
    cmd_c.kind    = CMD_REPLY3;
    cmd_c.b1      = B_DONT;
    cmd_c.b2      = rx_byte;
    cmd_c.echo    = 1'b0;
    want          = (sub_cnt_r == 2'd0) ? B_SEND : ((sub_cnt_r == 2'd1) ? B_IAC : B_SE);
    match_c       = sub_match_r & (rx_byte == want);

    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == B_IAC) begin
          phase_nxt = PH_IAC;
        end else begin
          push_c     = 1'b1;
          cmd_c.kind = CMD_DATA;
          cmd_c.b1   = rx_byte;
        end
      end
      PH_IAC: begin
        case (rx_byte)
          B_IAC: begin
            push_c     = 1'b1;
            cmd_c.kind = CMD_DATA;
            cmd_c.b1   = B_IAC;
          end
          B_SB: begin
            verb_nxt  = V_SB;
            phase_nxt = PH_OPT;
          end
          B_DO: begin
            verb_nxt  = V_DO;
            phase_nxt = PH_OPT;
          end
          B_DONT: begin
            verb_nxt  = V_DONT;
            phase_nxt = PH_OPT;
          end
          B_WILL: begin
            verb_nxt  = V_WILL;
            phase_nxt = PH_OPT;
          end
          B_WONT: begin
            verb_nxt  = V_WONT;
            phase_nxt = PH_OPT;
          end
          default: ;  // unknown verb swallowed
        endcase
      end
      PH_OPT: begin
        case (verb_r)
          V_SB: begin
            if (rx_byte == OPT_TTYPE && tt_present) begin
              phase_nxt     = PH_SUB;
              sub_cnt_nxt   = 2'd0;
              sub_match_nxt = 1'b1;
            end
          end
          V_DO: begin
            push_c = 1'b1;
            if (rx_byte == OPT_SGA) begin
              cmd_c.b1 = B_WILL;
            end else if (rx_byte == OPT_TTYPE) begin
              cmd_c.b1 = tt_present ? B_WILL : B_WONT;
            end else if (rx_byte == OPT_NAWS) begin
              cmd_c.kind = CMD_NAWS;
            end else begin
              cmd_c.b1 = B_WONT;
            end
          end
          V_DONT: begin
            push_c   = 1'b1;
            cmd_c.b1 = B_WONT;
          end
          V_WILL: begin
            push_c = 1'b1;
            if (rx_byte == OPT_ECHO) begin
              cmd_c.b1   = B_DO;
              cmd_c.echo = 1'b1;
            end else if (rx_byte == OPT_SGA) begin
              cmd_c.b1 = B_DO;
            end
          end
          default: begin
            push_c = 1'b1;
          end
        endcase
      end
      PH_SUB: begin
        if (sub_cnt_r != 2'd2) begin
          phase_nxt     = PH_SUB;
          sub_cnt_nxt   = sub_cnt_r + 2'd1;
          sub_match_nxt = match_c;
        end else begin
          push_c        = match_c;
          cmd_c.kind    = CMD_TTIS;
          sub_cnt_nxt   = 2'd0;
          sub_match_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      verb_r      <= V_SB;
      sub_cnt_r   <= 2'd0;
      sub_match_r <= 1'b1;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      verb_r      <= verb_nxt;
      sub_cnt_r   <= sub_cnt_nxt;
      sub_match_r <= sub_match_nxt;
    end
  end

  assign q_push  = accept & push_c;
  assign q_wdata = cmd_c;

endmodule

// File: rtl/tonc_queue.sv
module tonc_queue
  import tonc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  input  logic pop,
  output cmd_t rdata,
  output logic full,
  output logic empty
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/tonc_back.sv
module tonc_back
  import tonc_pkg::*;
#(
  parameter int TT_W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic [TT_W-1:0]  tt_chars,
  input  logic [LEN_W-1:0] tt_len,
  input  logic [15:0]      columns,
  input  logic [15:0]      rows,
  output logic             out_valid,
  input  logic             out_pop,
  output logic             out_dest,
  output logic [7:0]       out_byte,
  output logic             out_echo_off,
  output logic             out_last
);

  logic [SEQ_W-1:0] k_r;
  logic             out_valid_r;
  logic             dest_r, echo_r, last_r;
  logic [7:0]       byte_r;

  logic             emit;
  logic [7:0]       byte_c;
  logic             last_c;
  logic [63:0]      tt64;
  logic [2:0]       ch_idx;
  logic [SEQ_W-1:0] tt_end;

  assign tt64   = 64'(tt_chars);
  assign ch_idx = 3'(k_r - SEQ_W'(4));
  assign tt_end = SEQ_W'(tt_len) + SEQ_W'(5);

  // beat k of the current command
  always_comb begin
    byte_c = B_IAC;
    last_c = 1'b0;
    case (cmd.kind)
      CMD_DATA: begin
        byte_c = cmd.b1;
        last_c = 1'b1;
      end
      CMD_REPLY3: begin
        case (k_r)
          SEQ_W'(0): byte_c = B_IAC;
          SEQ_W'(1): byte_c = cmd.b1;
          default:   byte_c = cmd.b2;
        endcase
        last_c = (k_r == SEQ_W'(2));
      end
      CMD_NAWS: begin
        case (k_r)
          SEQ_W'(0):  byte_c = B_IAC;
          SEQ_W'(1):  byte_c = B_WILL;
          SEQ_W'(2):  byte_c = OPT_NAWS;
          SEQ_W'(3):  byte_c = B_IAC;
          SEQ_W'(4):  byte_c = B_SB;
          SEQ_W'(5):  byte_c = OPT_NAWS;
          SEQ_W'(6):  byte_c = columns[15:8];
          SEQ_W'(7):  byte_c = columns[7:0];
          SEQ_W'(8):  byte_c = rows[15:8];
          SEQ_W'(9):  byte_c = rows[7:0];
          SEQ_W'(10): byte_c = B_IAC;
          default:    byte_c = B_SE;
        endcase
        last_c = (k_r == SEQ_W'(11));
      end
      CMD_TTIS: begin
        if (k_r == SEQ_W'(0)) begin
          byte_c = B_IAC;
        end else if (k_r == SEQ_W'(1)) begin
          byte_c = B_SB;
        end else if (k_r == SEQ_W'(2)) begin
          byte_c = OPT_TTYPE;
        end else if (k_r == SEQ_W'(3)) begin
          byte_c = B_IS;
        end else if (k_r < tt_end - SEQ_W'(1)) begin
          byte_c = tt64[ch_idx*8 +: 8];
        end else if (k_r == tt_end - SEQ_W'(1)) begin
          byte_c = B_IAC;
        end else begin
          byte_c = B_SE;
        end
        last_c = (k_r == tt_end);
      end
      default: ;
    endcase
  end

  assign emit  = !q_empty && (!out_valid_r || out_pop);
  assign q_pop = emit && last_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        k_r <= last_c ? '0 : k_r + SEQ_W'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dest_r <= (cmd.kind != CMD_DATA);
      byte_r <= byte_c;
      echo_r <= cmd.echo & last_c;
      last_r <= last_c;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dest     = dest_r;
  assign out_byte     = byte_r;
  assign out_echo_off = echo_r;
  assign out_last     = last_r;

  a_seq_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != '0) |-> !q_empty)
    else $error("beat counter mid-command with no command queued");

  a_echo_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_echo_off) |-> out_last)
    else $error("echo_off on a beat that is not last");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> (out_valid_r && $stable(byte_r) && $stable(last_r)))
    else $error("stalled result beat changed");

  a_pop_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (emit && last_c))
    else $error("command retired before its last beat");

endmodule

// File: rtl/telnet_option_negotiator_core.sv
// Telnet option negotiator. Received bytes enter on in_push/in_full, at most one per cycle,
// and are taken every cycle while the four-entry command queue between the parser and the
// reply generator has room. Plain bytes come out as one data beat (dest 0); option commands
// come out as reply beats to the host (dest 1): three for an ordinary reply, twelve for the
// NAWS answer, six plus the term type length for the term type answer. The reply generator
// sends one beat per cycle unless out_pop stalls it, and the parser keeps accepting while
// replies drain. out_last marks a byte's final beat. Configuration writes are taken at once
// and must be made while the block is idle.
module telnet_option_negotiator_core
  import tonc_pkg::*;
#(
  parameter int TERM_TYPE_MAX_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_rx_byte,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_dest,
  output logic [7:0]  out_out_byte,
  output logic        out_echo_off,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_data
);

  localparam int TT_W = 8 * TERM_TYPE_MAX_CHARS;

  logic [TT_W-1:0]  tt_chars_r;
  logic [LEN_W-1:0] tt_len_r;
  logic [15:0]      columns_r;
  logic [15:0]      rows_r;
  logic [LEN_W-1:0] tt_len_eff;

  logic accept;
  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_wdata, q_rdata;
  logic out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tt_chars_r <= '0;
      tt_len_r   <= '0;
      columns_r  <= 16'd80;
      rows_r     <= 16'd24;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TT_CHARS: tt_chars_r <= cfg_data[TT_W-1:0];
        CFG_TT_LEN:   tt_len_r   <= cfg_data[LEN_W-1:0];
        CFG_COLUMNS:  columns_r  <= cfg_data[15:0];
        CFG_ROWS:     rows_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign tt_len_eff = (tt_len_r > LEN_W'(TERM_TYPE_MAX_CHARS)) ?
                      LEN_W'(TERM_TYPE_MAX_CHARS) : tt_len_r;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  tonc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .rx_byte    (in_rx_byte),
    .tt_present (tt_len_eff != '0),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  tonc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  tonc_back #(
    .TT_W (TT_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .tt_chars     (tt_chars_r),
    .tt_len       (tt_len_eff),
    .columns      (columns_r),
    .rows         (rows_r),
    .out_valid    (out_valid),
    .out_pop      (out_pop),
    .out_dest     (out_dest),
    .out_byte     (out_out_byte),
    .out_echo_off (out_echo_off),
    .out_last     (out_last)
  );

  assign out_empty = !out_valid;

endmodule

// File: bench/tb_telnet_option_negotiator_core.sv
module tb_telnet_option_negotiator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tonc_pkg::*;

  localparam int MAX_TT_CHARS = 8;
  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BYTES = 56;
  localparam int MAX_PRINTED = 60;

  typedef enum logic [1:0] {PH_IDLE, PH_IAC, PH_OPT, PH_SUB} parse_ph_t;
  typedef enum logic [2:0] {VB_SB, VB_DO, VB_DONT, VB_WILL, VB_WONT} verb_t;

  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       echo;
    logic       last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_full;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_dest;
  logic [7:0]  out_out_byte;
  logic        out_echo_off;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_TT_CHARS;
  logic [63:0] cfg_data = 64'h0;

  telnet_option_negotiator_core #(.TERM_TYPE_MAX_CHARS(MAX_TT_CHARS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_rx_byte   (in_rx_byte),
    .in_full      (in_full),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_dest     (out_dest),
    .out_out_byte (out_out_byte),
    .out_echo_off (out_echo_off),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  wire in_fire  = in_push && !in_full;
  wire out_fire = out_pop && !out_empty;

  // shadow registers and parser state
  logic [63:0] tt_chars = 64'h0;
  logic [3:0]  tt_len = 4'd0;
  logic [15:0] naws_cols = 16'd80;
  logic [15:0] naws_rows = 16'd24;
  parse_ph_t   ph = PH_IDLE;
  verb_t       verb = VB_SB;
  logic [1:0]  sub_cnt = 2'd0;
  logic        sub_ok = 1'b1;

  logic [7:0] rx_backlog[$];
  beat_t      reply_buf[$];
  beat_t      due_beats[$];

  int queued_bytes = 0;
  int fed_bytes = 0;
  int term_beats = 0;
  int host_beats = 0;
  int settings = 1;
  int errors = 0;
  int quiet_cycles = 0;

  task automatic log_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  function automatic logic [3:0] tt_eff_len();
    return (tt_len > MAX_TT_CHARS) ? 4'(MAX_TT_CHARS) : tt_len;
  endfunction

  task automatic put_beat(input logic dest, input logic [7:0] b);
    reply_buf.push_back('{dest: dest, data: b, echo: 1'b0, last: 1'b0});
  endtask

  task automatic put_triplet(input logic [7:0] v, input logic [7:0] opt);
    put_beat(1'b1, B_IAC);
    put_beat(1'b1, v);
    put_beat(1'b1, opt);
  endtask

  // Runs the parser on one received byte and queues the beats it must produce.
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [7:0] want;
    logic       echo;
    int         i;
    echo = 1'b0;
    reply_buf.delete();
    case (ph)
      PH_IAC: begin
        ph = PH_IDLE;
        if (b == B_IAC) put_beat(1'b0, B_IAC);
        else if (b == B_SB) begin verb = VB_SB; ph = PH_OPT; end
        else if (b == B_DO) begin verb = VB_DO; ph = PH_OPT; end
        else if (b == B_DONT) begin verb = VB_DONT; ph = PH_OPT; end
        else if (b == B_WILL) begin verb = VB_WILL; ph = PH_OPT; end
        else if (b == B_WONT) begin verb = VB_WONT; ph = PH_OPT; end
      end
      PH_OPT: begin
        ph = PH_IDLE;
        case (verb)
          VB_SB: begin
            if (b == OPT_TTYPE && tt_eff_len() != 0) begin
              ph = PH_SUB;
              sub_cnt = 2'd0;
              sub_ok = 1'b1;
            end
          end
          VB_DO: begin
            if (b == OPT_SGA) put_triplet(B_WILL, OPT_SGA);
            else if (b == OPT_TTYPE) put_triplet(tt_eff_len() != 0 ? B_WILL : B_WONT, OPT_TTYPE);
            else if (b == OPT_NAWS) begin
              put_triplet(B_WILL, OPT_NAWS);
              put_triplet(B_SB, OPT_NAWS);
              put_beat(1'b1, naws_cols[15:8]);
              put_beat(1'b1, naws_cols[7:0]);
              put_beat(1'b1, naws_rows[15:8]);
              put_beat(1'b1, naws_rows[7:0]);
              put_beat(1'b1, B_IAC);
              put_beat(1'b1, B_SE);
            end else put_triplet(B_WONT, b);
          end
          VB_DONT: put_triplet(B_WONT, b);
          VB_WILL: begin
            if (b == OPT_ECHO) begin
              put_triplet(B_DO, OPT_ECHO);
              echo = 1'b1;
            end else if (b == OPT_SGA) put_triplet(B_DO, OPT_SGA);
            else put_triplet(B_DONT, b);
          end
          default: put_triplet(B_DONT, b);
        endcase
      end
      PH_SUB: begin
        want = (sub_cnt == 2'd0) ? B_SEND : (sub_cnt == 2'd1) ? B_IAC : B_SE;
        if (b != want) sub_ok = 1'b0;
        if (sub_cnt < 2'd2) sub_cnt++;
        else begin
          // length is taken as it stands when SE arrives
          if (sub_ok) begin
            put_triplet(B_SB, OPT_TTYPE);
            put_beat(1'b1, B_IS);
            for (i = 0; i < int'(tt_eff_len()); i++) put_beat(1'b1, tt_chars[8*i +: 8]);
            put_beat(1'b1, B_IAC);
            put_beat(1'b1, B_SE);
          end
          ph = PH_IDLE;
          sub_cnt = 2'd0;
          sub_ok = 1'b1;
        end
      end
      default: begin
        if (b == B_IAC) ph = PH_IAC;
        else put_beat(1'b0, b);
      end
    endcase
    if (reply_buf.size() > 0) begin
      reply_buf[reply_buf.size()-1].last = 1'b1;
      reply_buf[reply_buf.size()-1].echo = echo;
    end
    foreach (reply_buf[k]) due_beats.push_back(reply_buf[k]);
  endtask

  // input driver
  int  in_gap = 0;
  bit  in_calm = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_fire) begin
        parse_rx_byte(in_rx_byte);
        fed_bytes++;
        if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 5);
      end
      if (!in_push || in_fire) begin
        if (in_gap > 0) begin
          in_gap--;
          in_push <= 1'b0;
        end else if (rx_backlog.size() > 0) begin
          in_push <= 1'b1;
          in_rx_byte <= rx_backlog.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int  out_stall = 0;
  bit  out_calm = 0;
  always @(posedge clk) begin
    beat_t exp_b;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_fire) begin
        if (out_dest) host_beats++;
        else term_beats++;
        if (due_beats.size() == 0) begin
          log_mismatch($sformatf("unexpected beat dest=%0d byte=%02h echo=%0d last=%0d",
                                 out_dest, out_out_byte, out_echo_off, out_last));
        end else begin
          exp_b = due_beats.pop_front();
          if (out_dest !== exp_b.dest)
            log_mismatch($sformatf("dest %0d, want %0d", out_dest, exp_b.dest));
          if (out_out_byte !== exp_b.data)
            log_mismatch($sformatf("byte %02h, want %02h", out_out_byte, exp_b.data));
          if (out_echo_off !== exp_b.echo)
            log_mismatch($sformatf("echo_off %0d, want %0d", out_echo_off, exp_b.echo));
          if (out_last !== exp_b.last)
            log_mismatch($sformatf("last %0d, want %0d", out_last, exp_b.last));
        end
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 5);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d beats still due", quiet_cycles,
                 due_beats.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic feed(input logic [7:0] b);
    rx_backlog.push_back(b);
    queued_bytes++;
  endtask

  // held at a posedge with cfg_we high; the caller drops cfg_we after the batch
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_TT_CHARS: tt_chars = val;
      CFG_TT_LEN:   tt_len = val[3:0];
      CFG_COLUMNS:  naws_cols = val[15:0];
      default:      naws_rows = val[15:0];
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Waits until every byte has gone in and every beat is out, plus a margin
  // for command bytes that produce nothing.
  task automatic wait_quiet();
    while (fed_bytes != queued_bytes || due_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return {8'hFF, 8'($urandom_range(0, 255))};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_settings();
    logic [63:0] chars;
    int j;
    chars = {$urandom, $urandom};
    for (j = 0; j < 8; j++) begin
      if ($urandom_range(0, 5) == 0) chars[8*j +: 8] = 8'h00;
      else if ($urandom_range(0, 5) == 0) chars[8*j +: 8] = 8'hFF;
    end
    if ($urandom_range(0, 3) != 0) write_reg(CFG_TT_CHARS, chars);
    case ($urandom_range(0, 3))
      0:       write_reg(CFG_TT_LEN, 64'd0);
      1:       write_reg(CFG_TT_LEN, 64'd8);
      2:       write_reg(CFG_TT_LEN, 64'd15);
      default: write_reg(CFG_TT_LEN, 64'($urandom_range(1, 15)));
    endcase
    if ($urandom_range(0, 3) != 0) write_reg(CFG_COLUMNS, {48'h0, pick_size()});
    if ($urandom_range(0, 3) != 0) write_reg(CFG_ROWS, {48'h0, pick_size()});
    end_writes();
  endtask

  // One command or data sequence; mostly well formed, some noise.
  task automatic feed_random_seq();
    int r;
    logic [7:0] opt;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 4))
      0:       opt = OPT_ECHO;
      1:       opt = OPT_SGA;
      2:       opt = OPT_TTYPE;
      3:       opt = OPT_NAWS;
      default: opt = 8'($urandom_range(0, 255));
    endcase
    if (r < 25) begin
      feed(8'($urandom_range(0, 254)));
    end else if (r < 30) begin
      feed(B_IAC); feed(B_IAC);
    end else if (r < 68) begin
      feed(B_IAC);
      case ($urandom_range(0, 3))
        0:       feed(B_DO);
        1:       feed(B_DONT);
        2:       feed(B_WILL);
        default: feed(B_WONT);
      endcase
      feed(opt);
    end else if (r < 85) begin
      feed(B_IAC); feed(B_SB); feed(OPT_TTYPE);
      // one of the trailing bytes is sometimes corrupted
      r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 3;
      feed(r == 0 ? 8'($urandom_range(0, 255)) : B_SEND);
      feed(r == 1 ? 8'($urandom_range(0, 255)) : B_IAC);
      feed(r == 2 ? 8'($urandom_range(0, 255)) : B_SE);
    end else if (r < 90) begin
      feed(B_IAC); feed(B_SB); feed(opt);
    end else if (r < 95) begin
      feed(B_IAC); feed(8'($urandom_range(0, 249)));
    end else begin
      feed(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int p;
    int start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: no term type, 80x24
    feed(8'h00); feed(B_IAC); feed(B_IAC);
    feed(B_IAC); feed(B_DO); feed(OPT_TTYPE);
    feed(B_IAC); feed(B_SB); feed(OPT_TTYPE); feed(B_SEND);
    feed(8'h7F);
    wait_quiet();

    // term type with zero and 255 bytes, length above the cap, extreme sizes
    write_reg(CFG_TT_CHARS, 64'hFF00_3030_3154_5456);
    write_reg(CFG_TT_LEN, 64'd15);
    write_reg(CFG_COLUMNS, 64'hFFFF);
    write_reg(CFG_ROWS, 64'h0000);
    end_writes();
    feed(B_IAC); feed(B_DO); feed(OPT_NAWS);
    feed(B_IAC); feed(B_SB); feed(OPT_TTYPE); feed(B_SEND); feed(B_IAC); feed(B_SE);
    feed(B_IAC); feed(8'h10);
    feed(B_IAC); feed(B_WILL); feed(OPT_ECHO);
    feed(B_IAC); feed(B_SB); feed(OPT_TTYPE); feed(B_SEND); feed(B_IAC);
    wait_quiet();

    // length drops to zero before SE: answer carries no characters
    write_reg(CFG_TT_LEN, 64'd0);
    end_writes();
    feed(B_SE);
    wait_quiet();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      random_settings();
      start = queued_bytes;
      while (queued_bytes - start < PHASE_BYTES) feed_random_seq();
      wait_quiet();
    end

    if (due_beats.size() != 0)
      log_mismatch($sformatf("%0d beats never arrived", due_beats.size()));
    $display("covered %0d rx bytes under %0d register settings", fed_bytes, settings);
    $display("%0d terminal beats, %0d host reply beats, %0d mismatches",
             term_beats, host_beats, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
